// ===== rtl/gbba_pkg.sv =====
// shared types, constants and codes for the grouped block bitmap allocator
`default_nettype none

package gbba_pkg;

   localparam int GROUPS_DEFAULT          = 4;
   localparam int WORDS_PER_GROUP_DEFAULT = 1024;

   localparam logic [31:0] FULL_WORD     = 32'hFFFF_FFFF;
   localparam int          BITS_PER_WORD = 32;

   localparam int CSR_ADDR_W = 4;

   localparam logic [15:0] BPG_RESET  = 16'd32768;
   localparam logic [2:0]  GCNT_RESET = 3'd4;
   localparam logic        FDB_RESET  = 1'b0;

   typedef enum logic [1:0] {
      CMD_ALLOC      = 2'd0,
      CMD_LOAD_WORD  = 2'd1,
      CMD_LOAD_COUNT = 2'd2,
      CMD_LOAD_TOTAL = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_BPG  = 2'd0,
      CSR_GCNT = 2'd1,
      CSR_FDB  = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GROUP,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  group;
      logic [9:0]  word_index;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [17:0] block_number;
      logic        found;
      logic [31:0] free_total;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/grouped_block_bitmap_allocator.sv =====
// first-fit block allocator over grouped usage bitmaps: sequencer, counts and csr port
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  gbba_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  gbba_pkg::rsp_type
//   csr      in/out     apb-style, pready = 1  three 32-bit registers at 0x0, 0x4, 0x8
//
// a load request gives no response; an allocate reads one word per cycle through
// the single read port of the bitmap ram
// after reset all GROUPS * WORDS_PER_GROUP ram words are zeroed; req_stall stays
// high until the sweep has ended
// req_stall is high while an allocate is in flight; a held response does not
// block loads, only the delivery of the next allocate result
`default_nettype none

module grouped_block_bitmap_allocator #(
   parameter int GROUPS          = gbba_pkg::GROUPS_DEFAULT,
   parameter int WORDS_PER_GROUP = gbba_pkg::WORDS_PER_GROUP_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire gbba_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output gbba_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gbba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int DEPTH = GROUPS * WORDS_PER_GROUP;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int WW    = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
   localparam int CNTW  = (GW + 1 > 3) ? GW + 1 : 3;

   function automatic logic [4:0] lowest_zero(input logic [31:0] word);
      logic [4:0] pos;
      pos = '0;
      for (int i = 31; i >= 0; i--) begin
         if (!word[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

   gbba_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]     g_ff, g_in;
   logic [WW-1:0]       w_ff, w_in;
   logic [17:0]         base_ff, base_in;
   logic [AW-1:0]       grp_addr_ff, grp_addr_in;
   logic [31:0]         hit_word_ff, hit_word_in;
   logic [4:0]          hit_bit_ff, hit_bit_in;
   logic [17:0]         blk_ff, blk_in;
   logic                found_ff, found_in;
   logic [31:0]         total_ff, total_in;
   logic [15:0]         bpg_ff, bpg_in;
   logic [2:0]          gcnt_ff, gcnt_in;
   logic                fdb_ff, fdb_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gbba_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [15:0]         cnt_ff [GROUPS];
   logic                cnt_we;
   logic [GW-1:0]       cnt_widx;
   logic [15:0]         cnt_wdata;

   logic                bm_we;
   logic [AW-1:0]       bm_waddr;
   logic [31:0]         bm_wdata;
   logic [AW-1:0]       bm_raddr;
   logic [31:0]         bm_rdata;
   logic                bm_busy;

   logic                req_accept;
   logic                csr_wr;
   logic [1:0]          csr_idx;
   logic [11:0]         words;
   logic [11:0]         words_raw;
   logic [CNTW-1:0]     limit;
   logic [GW-1:0]       g_idx;
   logic [4:0]          zero_bit;
   logic [WW+4:0]       scan_idx;
   logic                next_grp;

   gbba_bitmap #(
      .DEPTH (DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata),
      .busy    (bm_busy)
   );

   assign req_stall  = (state_ff != gbba_pkg::ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      case (csr_idx)
         gbba_pkg::CSR_BPG:  csr_prdata = {16'd0, bpg_ff};
         gbba_pkg::CSR_GCNT: csr_prdata = {29'd0, gcnt_ff};
         gbba_pkg::CSR_FDB:  csr_prdata = {31'd0, fdb_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // scan geometry: words per group, number of groups searched and the lowest clear bit of the word read
   always_comb begin
      words_raw = 12'(({1'b0, bpg_ff} + 17'd31) >> 5);
      words     = (words_raw > 12'(WORDS_PER_GROUP)) ? 12'(WORDS_PER_GROUP) : words_raw;
      limit     = (32'(gcnt_ff) < GROUPS) ? CNTW'(gcnt_ff) : CNTW'(GROUPS);
      g_idx     = g_ff[GW-1:0];
      zero_bit  = lowest_zero(bm_rdata);
      scan_idx  = {w_ff, zero_bit};
   end

   always_comb begin
      state_in     = state_ff;
      g_in         = g_ff;
      w_in         = w_ff;
      base_in      = base_ff;
      grp_addr_in  = grp_addr_ff;
      hit_word_in  = hit_word_ff;
      hit_bit_in   = hit_bit_ff;
      blk_in       = blk_ff;
      found_in     = found_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cnt_we       = 1'b0;
      cnt_widx     = g_idx;
      cnt_wdata    = cnt_ff[g_idx] - 16'd1;
      bm_we        = 1'b0;
      bm_waddr     = grp_addr_ff + AW'(w_ff);
      bm_wdata     = hit_word_ff | (32'd1 << hit_bit_ff);
      bm_raddr     = (state_ff == gbba_pkg::ST_SCAN) ?
                     grp_addr_ff + AW'(w_ff) + AW'(1) : grp_addr_ff;
      next_grp     = 1'b0;

      bpg_in  = bpg_ff;
      gcnt_in = gcnt_ff;
      fdb_in  = fdb_ff;
      if (csr_wr) begin
         case (csr_idx)
            gbba_pkg::CSR_BPG:  bpg_in  = csr_pwdata[15:0];
            gbba_pkg::CSR_GCNT: gcnt_in = csr_pwdata[2:0];
            gbba_pkg::CSR_FDB:  fdb_in  = csr_pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         gbba_pkg::ST_CLEAR: begin
            if (!bm_busy) begin
               state_in = gbba_pkg::ST_IDLE;
            end
         end
         gbba_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_data.cmd)
                  gbba_pkg::CMD_ALLOC: begin
                     g_in        = '0;
                     base_in     = '0;
                     grp_addr_in = '0;
                     state_in    = gbba_pkg::ST_GROUP;
                  end
                  gbba_pkg::CMD_LOAD_WORD: begin
                     bm_we    = (32'(req_data.group) < GROUPS) &&
                                (32'(req_data.word_index) < WORDS_PER_GROUP);
                     bm_waddr = AW'(32'(req_data.group) * WORDS_PER_GROUP +
                                    32'(req_data.word_index));
                     bm_wdata = req_data.value;
                  end
                  gbba_pkg::CMD_LOAD_COUNT: begin
                     cnt_we    = (32'(req_data.group) < GROUPS);
                     cnt_widx  = GW'(req_data.group);
                     cnt_wdata = req_data.value[15:0];
                  end
                  gbba_pkg::CMD_LOAD_TOTAL: begin
                     total_in = req_data.value;
                  end
                  default: ;
               endcase
            end
         end
         gbba_pkg::ST_GROUP: begin
            w_in = '0;
            if (g_ff >= limit) begin
               // no group left: report failure
               blk_in   = '0;
               found_in = 1'b0;
               state_in = gbba_pkg::ST_RESP;
            end else if (cnt_ff[g_idx] == 16'd0 || words == 12'd0) begin
               next_grp = 1'b1;
            end else begin
               state_in = gbba_pkg::ST_SCAN;
            end
         end
         gbba_pkg::ST_SCAN: begin
            if (bm_rdata != gbba_pkg::FULL_WORD) begin
               if (16'(scan_idx) < bpg_ff) begin
                  hit_word_in = bm_rdata;
                  hit_bit_in  = zero_bit;
                  state_in    = gbba_pkg::ST_COMMIT;
               end else begin
                  // only padding bits past the group end are clear
                  next_grp = 1'b1;
               end
            end else if ((12'(w_ff) + 12'd1) < words) begin
               w_in = w_ff + WW'(1);
            end else begin
               next_grp = 1'b1;
            end
         end
         gbba_pkg::ST_COMMIT: begin
            bm_we    = 1'b1;
            cnt_we   = 1'b1;
            if (total_ff != 32'd0) begin
               total_in = total_ff - 32'd1;
            end
            blk_in   = base_ff + 18'({w_ff, hit_bit_ff}) + 18'(fdb_ff);
            found_in = 1'b1;
            state_in = gbba_pkg::ST_RESP;
         end
         gbba_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.block_number = blk_ff;
               rsp_data_in.found        = found_ff;
               rsp_data_in.free_total   = total_ff;
               state_in                 = gbba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gbba_pkg::ST_IDLE;
         end
      endcase

      if (next_grp) begin
         g_in        = g_ff + CNTW'(1);
         base_in     = base_ff + {2'b00, bpg_ff};
         grp_addr_in = grp_addr_ff + AW'(WORDS_PER_GROUP);
         state_in    = gbba_pkg::ST_GROUP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbba_pkg::ST_CLEAR;
         total_ff     <= '0;
         bpg_ff       <= gbba_pkg::BPG_RESET;
         gcnt_ff      <= gbba_pkg::GCNT_RESET;
         fdb_ff       <= gbba_pkg::FDB_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         bpg_ff       <= bpg_in;
         gcnt_ff      <= gcnt_in;
         fdb_ff       <= fdb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      w_ff        <= w_in;
      base_ff     <= base_in;
      grp_addr_ff <= grp_addr_in;
      hit_word_ff <= hit_word_in;
      hit_bit_ff  <= hit_bit_in;
      blk_ff      <= blk_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GROUPS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         cnt_ff[cnt_widx] <= cnt_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // ram sweep only runs while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      bm_busy |-> state_ff == gbba_pkg::ST_CLEAR)
      else $error("bitmap sweep active outside clear state");

   // a failed allocation reports block zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |-> rsp_data_ff.block_number == 18'd0)
      else $error("failed allocation with nonzero block number");

   // the total never grows while an allocate is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != gbba_pkg::ST_IDLE && state_ff != gbba_pkg::ST_CLEAR)
      |=> total_ff <= $past(total_ff))
      else $error("free total increased during allocation");

   // a new response is only loaded from the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == gbba_pkg::ST_RESP)
      else $error("response raised outside response state");
`endif

endmodule

`default_nettype wire

// ===== rtl/gbba_bitmap.sv =====
// usage bitmap memory with registered read and a zeroing sweep after reset
`default_nettype none

module gbba_bitmap #(
   parameter int DEPTH = gbba_pkg::GROUPS_DEFAULT * gbba_pkg::WORDS_PER_GROUP_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data,
   output logic               busy
);

   logic [31:0]   mem_ff [DEPTH];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          busy_ff, busy_in;
   logic          we;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
      // the sweep owns the write port until every word is zero
      we    = busy_ff | wr_en;
      waddr = busy_ff ? clr_addr_ff : wr_addr;
      wdata = busy_ff ? 32'd0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         busy_ff     <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire
